// ===== rtl/ipv6p_pkg.sv =====
`timescale 1ns / 1ps
package ipv6p_pkg;

    localparam logic [3:0]  GROUPS_TOTAL    = 4'd8;
    localparam logic [3:0]  GROUPS_WITH_GAP = 4'd7;
    localparam logic [2:0]  GROUP_DIGITS    = 3'd4;
    localparam logic [11:0] ZONE_MAX        = 12'd255;

    typedef logic [2:0] t_kind;

    localparam t_kind K_DEC   = 3'd0;
    localparam t_kind K_ALPHA = 3'd1;
    localparam t_kind K_COLON = 3'd2;
    localparam t_kind K_PCT   = 3'd3;
    localparam t_kind K_OTHER = 3'd4;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_in;

    typedef struct packed {
        logic        valid_res;
        logic [63:0] address_high;
        logic [63:0] address_low;
        logic [7:0]  zone;
    } t_res;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] value;
        logic       last;
    } t_tok;

endpackage

// ===== rtl/ipv6p_front.sv =====
`timescale 1ns / 1ps
module ipv6p_front import ipv6p_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_in  i_item,
    input  logic i_take,
    output logic o_tok_valid,
    output t_tok o_tok
);

    localparam logic [7:0] CH_0     = "0";
    localparam logic [7:0] CH_9     = "9";
    localparam logic [7:0] CH_LA    = "a";
    localparam logic [7:0] CH_LF    = "f";
    localparam logic [7:0] CH_UA    = "A";
    localparam logic [7:0] CH_UF    = "F";
    localparam logic [7:0] CH_COLON = ":";
    localparam logic [7:0] CH_PCT   = "%";

    t_tok       n_tok;
    t_tok       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_wr;

    always_comb begin
        n_tok.last  = i_item.last;
        n_tok.value = 4'd0;
        n_tok.kind  = K_OTHER;
        if (i_item.character >= CH_0 && i_item.character <= CH_9) begin
            n_tok.kind  = K_DEC;
            n_tok.value = i_item.character[3:0];
        end else if ((i_item.character >= CH_LA && i_item.character <= CH_LF) ||
                     (i_item.character >= CH_UA && i_item.character <= CH_UF)) begin
            n_tok.kind  = K_ALPHA;
            n_tok.value = i_item.character[3:0] + 4'd9;
        end else if (i_item.character == CH_COLON) begin
            n_tok.kind  = K_COLON;
        end else if (i_item.character == CH_PCT) begin
            n_tok.kind  = K_PCT;
        end
    end

    assign full        = (r_cnt == 2'd2);
    assign w_wr        = push && !full;
    assign o_tok_valid = (r_cnt != 2'd0);
    assign o_tok       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (i_take) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, i_take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= n_tok;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("token queue count out of range");

    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take |-> o_tok_valid) else $error("token taken from empty queue");

endmodule

// ===== rtl/ipv6p_back.sv =====
`timescale 1ns / 1ps
module ipv6p_back import ipv6p_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_tok_valid,
    input  t_tok i_tok,
    output logic o_take,
    output logic empty,
    input  logic pop,
    output t_res o_result
);

    localparam logic [1:0] AC_NONE  = 2'd0;
    localparam logic [1:0] AC_GROUP = 2'd1;
    localparam logic [1:0] AC_DOUBLE = 2'd2;
    localparam logic [1:0] AC_LEAD  = 2'd3;
    localparam logic [2:0] DIGITS_SAT = 3'd5;

    typedef struct packed {
        logic [15:0] cur;
        logic [2:0]  dcnt;
        logic [3:0]  head;
        logic [3:0]  tail;
        logic        dcs;
        logic [1:0]  ac;
        logic        inz;
        logic [7:0]  zval;
        logic        zdig;
        logic        err;
    } t_ps;

    typedef struct packed {
        t_ps         st;
        logic        wr_head;
        logic        wr_tail;
        logic [2:0]  wr_idx;
        logic [15:0] wr_val;
    } t_step;

    function automatic t_step f_close(input t_step s);
        t_step r;
        r = s;
        if (r.st.dcnt > GROUP_DIGITS) begin
            r.st.err = 1'b1;
        end else if (!r.st.dcs) begin
            if (r.st.head >= GROUPS_TOTAL) begin
                r.st.err = 1'b1;
            end else begin
                r.wr_head = 1'b1;
                r.wr_idx  = r.st.head[2:0];
                r.wr_val  = r.st.cur;
                r.st.head = r.st.head + 4'd1;
                r.st.cur  = 16'd0;
                r.st.dcnt = 3'd0;
            end
        end else begin
            if ({1'b0, r.st.head} + {1'b0, r.st.tail} >= {1'b0, GROUPS_WITH_GAP}) begin
                r.st.err = 1'b1;
            end else begin
                r.wr_tail = 1'b1;
                r.wr_val  = r.st.cur;
                r.st.tail = r.st.tail + 4'd1;
                r.st.cur  = 16'd0;
                r.st.dcnt = 3'd0;
            end
        end
        return r;
    endfunction

    function automatic t_step f_finish(input t_step s);
        t_step r;
        r = s;
        if (r.st.dcnt != 3'd0) begin
            r = f_close(r);
            r.st.ac = AC_NONE;
            if (!r.st.err && !r.st.dcs && r.st.head != GROUPS_TOTAL) begin
                r.st.err = 1'b1;
            end
        end else if (r.st.ac != AC_DOUBLE) begin
            r.st.err = 1'b1;
        end else if (!r.st.dcs && r.st.head != GROUPS_TOTAL) begin
            r.st.err = 1'b1;
        end
        return r;
    endfunction

    t_ps         r_st;
    t_step       s;
    logic [11:0] w_zsum;
    logic        w_take;
    logic [15:0] r_head_g [8];
    logic [15:0] r_tail_g [8];
    logic [15:0] n_head_g [8];
    logic [15:0] n_tail_g [8];
    logic [15:0] w_g [8];
    t_res        n_res;
    t_res        r_oq [2];
    logic        r_owp;
    logic        r_orp;
    logic [1:0]  r_ocnt;
    logic        w_opush;
    logic        w_opop;

    assign w_take = i_tok_valid && (!i_tok.last || r_ocnt != 2'd2);
    assign o_take = w_take;
    assign w_zsum = {1'b0, r_st.zval, 3'b000} + {3'b000, r_st.zval, 1'b0}
                  + {8'd0, i_tok.value};

    always_comb begin
        s.st      = r_st;
        s.wr_head = 1'b0;
        s.wr_tail = 1'b0;
        s.wr_idx  = 3'd0;
        s.wr_val  = r_st.cur;
        if (!s.st.err) begin
            if (s.st.inz) begin
                if (i_tok.kind != K_DEC) begin
                    s.st.err = 1'b1;
                end else if (w_zsum > ZONE_MAX) begin
                    s.st.err = 1'b1;
                end else begin
                    s.st.zval = w_zsum[7:0];
                    s.st.zdig = 1'b1;
                end
            end else begin
                case (i_tok.kind)
                    K_DEC, K_ALPHA: begin
                        if (s.st.ac == AC_LEAD) begin
                            s.st.err = 1'b1;
                        end else begin
                            s.st.ac  = AC_NONE;
                            s.st.cur = {s.st.cur[11:0], i_tok.value};
                            if (s.st.dcnt < DIGITS_SAT) begin
                                s.st.dcnt = s.st.dcnt + 3'd1;
                            end
                        end
                    end
                    K_COLON: begin
                        if (s.st.dcnt != 3'd0) begin
                            s = f_close(s);
                            s.st.ac = AC_GROUP;
                        end else if (s.st.ac == AC_GROUP || s.st.ac == AC_LEAD) begin
                            if (s.st.dcs || s.st.head > GROUPS_WITH_GAP) begin
                                s.st.err = 1'b1;
                            end else begin
                                s.st.dcs = 1'b1;
                                s.st.ac  = AC_DOUBLE;
                            end
                        end else if (s.st.ac == AC_NONE) begin
                            s.st.ac = AC_LEAD;
                        end else begin
                            s.st.err = 1'b1;
                        end
                    end
                    K_PCT: begin
                        s = f_finish(s);
                        s.st.inz = 1'b1;
                    end
                    default: begin
                        s.st.err = 1'b1;
                    end
                endcase
            end
        end
        if (i_tok.last && !s.st.err) begin
            if (s.st.inz) begin
                if (!s.st.zdig) begin
                    s.st.err = 1'b1;
                end
            end else begin
                s = f_finish(s);
            end
        end
    end

    always_comb begin
        n_head_g = r_head_g;
        if (s.wr_head) begin
            n_head_g[s.wr_idx] = s.wr_val;
        end
        n_tail_g = r_tail_g;
        if (s.wr_tail) begin
            for (int i = 0; i < 7; i++) begin
                n_tail_g[i] = r_tail_g[i + 1];
            end
            n_tail_g[7] = s.wr_val;
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < s.st.head) begin
                w_g[i] = n_head_g[i];
            end else if (4'(i) >= GROUPS_TOTAL - s.st.tail) begin
                w_g[i] = n_tail_g[i];
            end else begin
                w_g[i] = 16'd0;
            end
        end
        n_res = '0;
        if (!s.st.err) begin
            n_res.valid_res = 1'b1;
            n_res.zone      = s.st.zval;
            for (int i = 0; i < 4; i++) begin
                n_res.address_high[16 * (3 - i) +: 16] = w_g[i];
                n_res.address_low[16 * (3 - i) +: 16]  = w_g[i + 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (w_take) begin
            if (i_tok.last) begin
                r_st <= '0;
            end else begin
                r_st <= s.st;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_head_g <= n_head_g;
            r_tail_g <= n_tail_g;
        end
    end

    assign w_opush  = w_take && i_tok.last;
    assign empty    = (r_ocnt == 2'd0);
    assign w_opop   = pop && !empty;
    assign o_result = r_oq[r_orp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (w_opush) begin
                r_owp <= ~r_owp;
            end
            if (w_opop) begin
                r_orp <= ~r_orp;
            end
            r_ocnt <= r_ocnt + {1'b0, w_opush} - {1'b0, w_opop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_opush) begin
            r_oq[r_owp] <= n_res;
        end
    end

    a_ocnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt != 2'd3) else $error("result queue count out of range");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_tok.last) |=> (r_st.head == 4'd0 && r_st.tail == 4'd0 &&
                                    !r_st.err && !r_st.inz && !r_st.dcs))
        else $error("parser state not cleared after last character");

    a_tail_needs_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_st.dcs |-> r_st.tail == 4'd0) else $error("tail group without double colon");

    a_group_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.dcs |-> ({1'b0, r_st.head} + {1'b0, r_st.tail} <= {1'b0, GROUPS_WITH_GAP}))
        else $error("group count exceeds limit with double colon");

endmodule

// ===== rtl/ipv6_text_address_parser.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// input     in         push / full          i_item   (character, last)
// result    out        empty / pop          o_result (valid_res, address_high,
//                                                      address_low, zone)
//
// One character per cycle sustained while the result queue has room; a result
// passes from the token queue through the combinational parser, which commits
// groups and aligns the address, into the result queue.
// Reset is synchronous and clears both queues and the parser state; the group
// registers hold until written. A full result queue holds the last character of
// a text at the head of the token queue; full rises once one more character waits.
module ipv6_text_address_parser import ipv6p_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_in  i_item,
    output logic empty,
    input  logic pop,
    output t_res o_result
);

    logic w_take;
    logic w_tok_valid;
    t_tok w_tok;

    ipv6p_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .i_take      (w_take),
        .o_tok_valid (w_tok_valid),
        .o_tok       (w_tok)
    );

    ipv6p_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (w_tok_valid),
        .i_tok       (w_tok),
        .o_take      (w_take),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import ipv6p_pkg::*;

    typedef enum logic [1:0] {
        COLON_NONE,
        COLON_AFTER_GROUP,
        COLON_DOUBLE,
        COLON_LEADING
    } t_colon;

    typedef struct packed {
        t_in  item;
        logic typed;
        t_res want;
    } t_feed;

    localparam int   NDIR     = 25;
    localparam t_res R_BAD    = '0;
    localparam t_res R_ZEROES = {1'b1, 64'h0, 64'h0, 8'd0};

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic push    = 1'b0;
    logic pop     = 1'b0;
    t_in  i_item  = '0;
    logic full;
    logic empty;
    t_res o_result;

    logic drv_typed = 1'b0;
    t_res drv_want  = '0;

    t_feed      feed_q[$];
    t_res       result_q[$];
    logic [7:0] text_buf[$];

    int n_fail     = 0;
    int n_pushed   = 0;
    int tx_gap     = 0;
    int tx_quiet   = 0;
    int rx_gap     = 0;
    int rx_quiet   = 0;
    int hold_left  = 0;
    logic hold_done = 1'b0;

    logic [15:0] grp_mem [8];
    logic [15:0] cur_grp;
    logic [2:0]  n_digits;
    logic [3:0]  n_head;
    logic [3:0]  n_tail;
    logic        dbl_seen;
    t_colon      colon_st;
    logic        in_zone;
    logic [7:0]  zone_val;
    logic        zone_seen;
    logic        err;

    string dir_text [NDIR] = '{
        "::",
        "0:0:0:0:0:0:0:0",
        "ffff:FFFF:ffff:FFFF:ffff:ffff:ffff:ffff",
        "::1",
        "1::",
        "fe80::1%255",
        "fe80::1%256",
        "%1",
        "12345::",
        ":1:2:3:4:5:6:7",
        "1:2:3:4:5:6:7:",
        "1:::2",
        "1::2::3",
        "1:2:3:4:5:6:7:8:9",
        "1:2:3:4::5:6:7:8",
        "1:2:3:4:5:6:7",
        "1:2:g::",
        "::1%",
        "::1%1%2",
        "::1%2a",
        ":",
        "1:2:3:4:5:6:7::",
        "::2:3:4:5:6:7:8",
        "aB:cD::Ef%0",
        "1::2:3%007"
    };

    logic dir_typed [NDIR] = '{
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
        1'b0, 1'b0, 1'b0, 1'b0
    };

    t_res dir_want [NDIR] = '{
        R_ZEROES,
        R_ZEROES,
        {1'b1, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 8'd0},
        {1'b1, 64'h0, 64'h1, 8'd0},
        {1'b1, 64'h0001_0000_0000_0000, 64'h0, 8'd0},
        {1'b1, 64'hfe80_0000_0000_0000, 64'h1, 8'd255},
        R_BAD, R_BAD, R_BAD, R_BAD, R_BAD, R_BAD, R_BAD, R_BAD,
        R_BAD, R_BAD, R_BAD, R_BAD, R_BAD, R_BAD, R_BAD,
        R_BAD, R_BAD, R_BAD, R_BAD
    };

    ipv6_text_address_parser dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_kind char_kind(logic [7:0] ch);
        if (ch >= 8'h30 && ch <= 8'h39) return K_DEC;
        if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) return K_ALPHA;
        if (ch == 8'h3a) return K_COLON;
        if (ch == 8'h25) return K_PCT;
        return K_OTHER;
    endfunction

    function automatic logic [3:0] hex_val(logic [7:0] ch);
        if (ch <= 8'h39) return 4'(ch - 8'h30);
        if (ch >= 8'h61) return 4'(ch - 8'h61 + 8'd10);
        return 4'(ch - 8'h41 + 8'd10);
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic clear_parse();
        cur_grp   = '0;
        n_digits  = '0;
        n_head    = '0;
        n_tail    = '0;
        dbl_seen  = 1'b0;
        colon_st  = COLON_NONE;
        in_zone   = 1'b0;
        zone_val  = '0;
        zone_seen = 1'b0;
        err       = 1'b0;
    endtask

    task automatic commit_group();
        logic [4:0] idx;
        if (n_digits > GROUP_DIGITS) begin
            err = 1'b1;
            return;
        end
        if (!dbl_seen) begin
            idx = {1'b0, n_head};
            if (idx >= GROUPS_TOTAL) begin
                err = 1'b1;
                return;
            end
            n_head = n_head + 4'd1;
        end else begin
            idx = {1'b0, n_head} + {1'b0, n_tail};
            if (idx >= GROUPS_WITH_GAP) begin
                err = 1'b1;
                return;
            end
            n_tail = n_tail + 4'd1;
        end
        grp_mem[idx[2:0]] = cur_grp;
        cur_grp  = '0;
        n_digits = '0;
    endtask

    task automatic end_address();
        if (n_digits > 0) begin
            commit_group();
            colon_st = COLON_NONE;
        end else if (colon_st != COLON_DOUBLE) begin
            err = 1'b1;
            return;
        end
        if (err) return;
        if (!dbl_seen && n_head != GROUPS_TOTAL) err = 1'b1;
    endtask

    task automatic address_char(logic [7:0] ch);
        case (char_kind(ch))
            K_DEC, K_ALPHA: begin
                if (colon_st == COLON_LEADING) begin
                    err = 1'b1;
                end else begin
                    colon_st = COLON_NONE;
                    cur_grp  = {cur_grp[11:0], hex_val(ch)};
                    if (n_digits < GROUP_DIGITS + 3'd1) n_digits = n_digits + 3'd1;
                end
            end
            K_COLON: begin
                if (n_digits > 0) begin
                    commit_group();
                    colon_st = COLON_AFTER_GROUP;
                end else if (colon_st == COLON_AFTER_GROUP || colon_st == COLON_LEADING) begin
                    if (dbl_seen || n_head > GROUPS_WITH_GAP) begin
                        err = 1'b1;
                    end else begin
                        dbl_seen = 1'b1;
                        colon_st = COLON_DOUBLE;
                    end
                end else if (colon_st == COLON_NONE) begin
                    colon_st = COLON_LEADING;
                end else begin
                    err = 1'b1;
                end
            end
            K_PCT: begin
                end_address();
                in_zone = 1'b1;
            end
            default: err = 1'b1;
        endcase
    endtask

    task automatic zone_char(logic [7:0] ch);
        logic [11:0] z;
        if (char_kind(ch) != K_DEC) begin
            err = 1'b1;
            return;
        end
        z = 12'(zone_val) * 12'd10 + 12'(hex_val(ch));
        if (z > ZONE_MAX) begin
            err = 1'b1;
            return;
        end
        zone_val  = z[7:0];
        zone_seen = 1'b1;
    endtask

    task automatic parse_char(input t_in it, output logic has_res, output t_res res);
        logic [15:0] g [8];
        int i;
        has_res = 1'b0;
        res     = '0;
        if (!err) begin
            if (in_zone) zone_char(it.character);
            else address_char(it.character);
        end
        if (!it.last) return;
        if (!err) begin
            if (in_zone) begin
                if (!zone_seen) err = 1'b1;
            end else begin
                end_address();
            end
        end
        if (!err) begin
            for (i = 0; i < 8; i++) g[i] = '0;
            for (i = 0; i < int'(n_head) && i < 8; i++) g[i] = grp_mem[i];
            for (i = 0; i < int'(n_tail) && i < 8; i++)
                g[(8 - int'(n_tail) + i) & 7] = grp_mem[(int'(n_head) + i) & 7];
            res.valid_res    = 1'b1;
            res.address_high = {g[0], g[1], g[2], g[3]};
            res.address_low  = {g[4], g[5], g[6], g[7]};
            res.zone         = zone_val;
        end
        clear_parse();
        has_res = 1'b1;
    endtask

    task automatic report_fail(string what, t_res want, t_res got);
        n_fail++;
        if (n_fail <= 10)
            $display("%s: valid %0d/%0d high %h/%h low %h/%h zone %0d/%0d (expected/actual)",
                     what, want.valid_res, got.valid_res, want.address_high,
                     got.address_high, want.address_low, got.address_low,
                     want.zone, got.zone);
    endtask

    task automatic feed_text(logic typed, t_res want);
        t_feed f;
        int i;
        for (i = 0; i < text_buf.size(); i++) begin
            f.item.character = text_buf[i];
            f.item.last      = (i == text_buf.size() - 1);
            f.typed          = typed;
            f.want           = want;
            feed_q.push_back(f);
        end
    endtask

    task automatic put_group();
        int n;
        int i;
        logic [3:0] v;
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) begin
            v = 4'($urandom_range(0, 15));
            if (v < 10) text_buf.push_back(8'h30 + 8'(v));
            else if ($urandom_range(0, 1)) text_buf.push_back(8'h41 + 8'(v) - 8'd10);
            else text_buf.push_back(8'h61 + 8'(v) - 8'd10);
        end
    endtask

    task automatic build_address();
        int h;
        int t;
        int i;
        int z;
        string s;
        if ($urandom_range(0, 3) == 0) begin
            for (i = 0; i < 8; i++) begin
                if (i > 0) text_buf.push_back(8'h3a);
                put_group();
            end
        end else begin
            h = $urandom_range(0, 7);
            t = $urandom_range(0, 7 - h);
            for (i = 0; i < h; i++) begin
                if (i > 0) text_buf.push_back(8'h3a);
                put_group();
            end
            text_buf.push_back(8'h3a);
            text_buf.push_back(8'h3a);
            for (i = 0; i < t; i++) begin
                if (i > 0) text_buf.push_back(8'h3a);
                put_group();
            end
        end
        if ($urandom_range(0, 9) < 4) begin
            text_buf.push_back(8'h25);
            z = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 255) : $urandom_range(256, 999);
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
                text_buf.push_back(8'h30);
            s = $sformatf("%0d", z);
            for (i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
        end
    endtask

    task automatic corrupt_text();
        int pos;
        pos = $urandom_range(0, text_buf.size() - 1);
        case ($urandom_range(0, 5))
            0: text_buf[pos] = 8'($urandom_range(0, 255));
            1: text_buf.insert(pos, 8'h3a);
            2: if (text_buf.size() > 1) text_buf.delete(pos);
            3: text_buf.insert(pos, 8'h30 + 8'($urandom_range(0, 9)));
            4: while (text_buf.size() > pos + 1) void'(text_buf.pop_back());
            default: text_buf.insert(pos, 8'h25);
        endcase
    endtask

    task automatic build_noise();
        string pool;
        pool = ":%0123abcF";
        repeat ($urandom_range(1, 12)) begin
            if ($urandom_range(0, 1)) text_buf.push_back(8'($urandom_range(0, 255)));
            else text_buf.push_back(pool[$urandom_range(0, pool.len() - 1)]);
        end
    endtask

    initial clear_parse();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || !full) begin
            if (push) begin
                if (tx_quiet > 0) begin
                    tx_quiet--;
                    tx_gap = 0;
                end else begin
                    tx_gap = gap_len();
                    if ($urandom_range(0, 39) == 0) tx_quiet = 40;
                end
            end
            if (tx_gap > 0) begin
                tx_gap--;
                push <= 1'b0;
            end else if (feed_q.size() > 0) begin
                t_feed f;
                f = feed_q.pop_front();
                i_item    <= f.item;
                drv_typed <= f.typed;
                drv_want  <= f.want;
                push      <= 1'b1;
            end else begin
                push <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && n_pushed >= 300) begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (rx_quiet > 0) begin
                    rx_quiet--;
                    rx_gap = 0;
                end else begin
                    rx_gap = gap_len();
                    if ($urandom_range(0, 19) == 0) rx_quiet = 10;
                end
            end
            if (hold_left > 0) begin
                pop <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        logic has_res;
        t_res pred;
        t_res want;
        if (i_rst_n) begin
            if (push && !full) begin
                n_pushed <= n_pushed + 1;
                parse_char(i_item, has_res, pred);
                if (has_res) result_q.push_back(drv_typed ? drv_want : pred);
            end
            if (pop && !empty) begin
                if (result_q.size() == 0) begin
                    report_fail("unexpected transfer", R_BAD, o_result);
                end else begin
                    want = result_q.pop_front();
                    if (o_result.valid_res !== want.valid_res ||
                        o_result.address_high !== want.address_high ||
                        o_result.address_low !== want.address_low ||
                        o_result.zone !== want.zone)
                        report_fail("mismatch", want, o_result);
                end
            end
        end
    end

    initial begin
        #(5_000_000);
        $display("tb: failure");
        $finish;
    end

    initial begin
        int k;
        int i;
        int n_items;
        int r;
        for (k = 0; k < NDIR; k++) begin
            text_buf.delete();
            for (i = 0; i < dir_text[k].len(); i++) text_buf.push_back(dir_text[k][i]);
            feed_text(dir_typed[k], dir_want[k]);
        end
        n_items = feed_q.size();
        while (n_items < 850) begin
            text_buf.delete();
            r = $urandom_range(0, 99);
            if (r < 8) begin
                build_noise();
            end else begin
                build_address();
                if (r >= 75) corrupt_text();
            end
            n_items += text_buf.size();
            feed_text(1'b0, R_BAD);
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (feed_q.size() != 0 || push) @(posedge i_clk);
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (n_fail == 0 && result_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== ipv6_text_address_parser.f =====
rtl/ipv6p_pkg.sv
rtl/ipv6p_front.sv
rtl/ipv6p_back.sv
rtl/ipv6_text_address_parser.sv
bench/tb.sv
